[rtl/wams_pkg.sv]
// Shared types and constants of the weighted adjacency matrix store.
package wams_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_FWD,
        ST_RD_REV,
        ST_UPD_FWD,
        ST_UPD_REV
    } wams_state_t;

    typedef enum logic [1:0] {
        KIND_INSERT      = 2'd0,
        KIND_REMOVE      = 2'd1,
        KIND_READ_EDGE   = 2'd2,
        KIND_READ_DEGREE = 2'd3
    } wams_kind_t;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_REJECTED = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    localparam logic [7:0] CFG_DIRECTED = 8'd0;
    localparam logic [7:0] CFG_VERTICES = 8'd1;

    localparam int KIND_W     = 2;
    localparam int VERT_W     = 6;
    localparam int WFIELD_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int DEG_W      = 8;
    localparam int EDGES_W    = 13;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_VERT_W = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_VERT_W-1:0] VERTICES_RESET = 7'd64;

endpackage

[rtl/weighted_adjacency_matrix_store_top.sv]
// Top level of the weighted adjacency matrix store: sequencer, matrix and degree memories.
//
// Requests arrive on the s_ channel: s_tuser carries the request kind, s_tdata the
// vertices and the weight. Each request returns exactly one word on the m_ channel
// with status, stored weight, source degree and total edge count.
// The cfg_ channel writes the two registers (directed mode, vertices in use); it is
// always ready and is meant to be written only while no request is in flight.
// Sequence: an accepted request steps through forward read, mirror read, forward
// update and mirror update; its result word becomes valid as s_tready goes high
// again, so the block takes no new request until the last one is through. The matrix
// memory reads the forward and the mirror entry in turn and then writes them in turn.
// After reset the block sweeps the matrix memory (and the degree memory alongside)
// to zero, one entry a cycle: MAX_VERTICES*MAX_VERTICES entries, 4096 at the default.
// s_tready stays low during the sweep; configuration writes are taken meanwhile.
// The result word sits in an output register; if the receiver stalls, the block
// finishes the next request up to its last step and holds there until the word
// ahead is taken.
module weighted_adjacency_matrix_store_top #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata fields from bit 0: source_vertex[5:0], target_vertex[11:6], weight[27:12]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wams_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser fields from bit 0: kind[1:0]
    input  logic [wams_pkg::KIND_W-1:0]         s_tuser,
    // m_tdata fields from bit 0: status[1:0], edge_weight[17:2], vertex_degree[25:18],
    // edge_count[38:26]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wams_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wams_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wams_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import wams_pkg::*;

    localparam int IW    = $clog2(MAX_VERTICES);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = ($clog2(MAX_VERTICES + 1) > CFG_VERT_W) ?
                           $clog2(MAX_VERTICES + 1) : CFG_VERT_W;

    // Memories
    logic [WEIGHT_BITS-1:0] mat_mem [DEPTH];
    logic [DEG_W-1:0]       deg_mem [MAX_VERTICES];
    logic [WEIGHT_BITS-1:0] mat_q;
    logic [DEG_W-1:0]       deg_q;

    // Sequencer and configuration
    wams_state_t            state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg;
    logic                   directed_reg;
    logic [CFG_VERT_W-1:0]  viu_reg;

    // Request held for the duration of its steps
    wams_kind_t             kind_reg;
    logic [VERT_W-1:0]      src_reg, dst_reg;
    logic [WEIGHT_BITS-1:0] wv_reg;
    logic                   src_ok_reg, dst_ok_reg;
    logic [WEIGHT_BITS-1:0] fwd_reg;
    logic [DEG_W-1:0]       dsrc_reg, ddst_reg, sdeg_new_reg;
    logic                   act_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [EDGES_W-1:0]     edge_reg;
    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;

    // Combinational control
    logic                   s_accept, out_free, self_loop;
    logic [IW-1:0]          src_i, dst_i;
    logic [AW-1:0]          fwd_addr, rev_addr;
    logic                   mat_we, mat_re, deg_we, deg_re;
    logic [AW-1:0]          mat_waddr, mat_raddr;
    logic [IW-1:0]          deg_waddr, deg_raddr;
    logic [WEIGHT_BITS-1:0] mat_wdata, new_w;
    logic [DEG_W-1:0]       deg_wdata, step_in, step_out, final_deg;
    logic [EDGES_W-1:0]     edge_step;
    logic                   present, range_ok, act_now;
    logic [STATUS_W-1:0]    status_now;
    logic [LW-1:0]          limit;
    logic                   in_src_ok, in_dst_ok;
    logic signed [31:0]     w_in_ext, ew_ext;
    logic [WEIGHT_BITS-1:0] ew_raw;
    logic [DEG_W-1:0]       deg_out;

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign self_loop = (src_reg == dst_reg);
    assign src_i     = IW'(src_reg);
    assign dst_i     = IW'(dst_reg);
    assign fwd_addr  = AW'(src_i) * AW'(MAX_VERTICES) + AW'(dst_i);
    assign rev_addr  = AW'(dst_i) * AW'(MAX_VERTICES) + AW'(src_i);
    assign new_w     = (kind_reg == KIND_INSERT) ? wv_reg : '0;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Range check of an incoming word against the capped vertex count.
    assign limit     = (LW'(viu_reg) > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : LW'(viu_reg);
    assign in_src_ok = LW'(s_tdata[5:0]) < limit;
    assign in_dst_ok = LW'(s_tdata[11:6]) < limit;
    assign w_in_ext  = 32'(signed'(s_tdata[27:12]));

    wams_sat_step #(.WIDTH(DEG_W)) u_deg_step (
        .value_in  (step_in),
        .count_up  (kind_reg == KIND_INSERT),
        .value_out (step_out)
    );

    wams_sat_step #(.WIDTH(EDGES_W)) u_edge_step (
        .value_in  (edge_reg),
        .count_up  (kind_reg == KIND_INSERT),
        .value_out (edge_step)
    );

    // Decision, made once both mirror entries have been read.
    always_comb begin
        present  = (fwd_reg != '0) || (!directed_reg && (mat_q != '0));
        range_ok = src_ok_reg && ((kind_reg == KIND_READ_DEGREE) || dst_ok_reg);
        act_now  = 1'b0;
        priority if (!range_ok) begin
            status_now = STATUS_RANGE;
        end else if (kind_reg == KIND_INSERT) begin
            if ((wv_reg == '0) || present) begin
                status_now = STATUS_REJECTED;
            end else begin
                status_now = STATUS_DONE;
                act_now    = 1'b1;
            end
        end else if (kind_reg == KIND_REMOVE) begin
            if (!present) begin
                status_now = STATUS_REJECTED;
            end else begin
                status_now = STATUS_DONE;
                act_now    = 1'b1;
            end
        end else begin
            status_now = STATUS_DONE;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_RD_FWD;
                end
            end
            ST_RD_FWD:  state_next = ST_RD_REV;
            ST_RD_REV:  state_next = ST_UPD_FWD;
            ST_UPD_FWD: state_next = ST_UPD_REV;
            ST_UPD_REV: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Memory port and handshake controls
    always_comb begin
        s_tready  = 1'b0;
        mat_we    = 1'b0;
        mat_re    = 1'b0;
        deg_we    = 1'b0;
        deg_re    = 1'b0;
        mat_waddr = fwd_addr;
        mat_raddr = fwd_addr;
        mat_wdata = new_w;
        deg_waddr = src_i;
        deg_raddr = src_i;
        step_in   = dsrc_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mat_we    = 1'b1;
                mat_waddr = clr_cnt_reg;
                mat_wdata = '0;
                deg_we    = (clr_cnt_reg < AW'(MAX_VERTICES));
                deg_waddr = IW'(clr_cnt_reg);
            end
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_RD_FWD: begin
                mat_re = 1'b1;
                deg_re = 1'b1;
            end
            ST_RD_REV: begin
                mat_re    = 1'b1;
                mat_raddr = rev_addr;
                deg_re    = 1'b1;
                deg_raddr = dst_i;
            end
            ST_UPD_FWD: begin
                mat_we = act_now;
                deg_we = act_now;
            end
            ST_UPD_REV: begin
                mat_we    = act_reg && !directed_reg;
                mat_waddr = rev_addr;
                deg_we    = act_reg;
                deg_waddr = dst_i;
                // A self-loop steps the source degree a second time.
                step_in   = self_loop ? sdeg_new_reg : ddst_reg;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Result word fields
    always_comb begin
        final_deg = (self_loop && act_reg) ? step_out : sdeg_new_reg;
        deg_out   = src_ok_reg ? final_deg : '0;
        if (src_ok_reg && dst_ok_reg && (kind_reg != KIND_READ_DEGREE)) begin
            ew_raw = act_reg ? new_w : fwd_reg;
        end else begin
            ew_raw = '0;
        end
        ew_ext = 32'(signed'(ew_raw));
    end

    always_ff @(posedge aclk) begin
        if (mat_we) begin
            mat_mem[mat_waddr] <= mat_wdata;
        end
        if (mat_re) begin
            mat_q <= mat_mem[mat_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (deg_re) begin
            deg_q <= deg_mem[deg_raddr];
        end
    end

    assign deg_wdata = (state_reg == ST_CLEAR) ? '0 : step_out;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            directed_reg <= 1'b0;
            viu_reg      <= VERTICES_RESET;
            edge_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_DIRECTED) begin
                    directed_reg <= cfg_data[0];
                end else if (cfg_index == CFG_VERTICES) begin
                    viu_reg <= cfg_data[CFG_VERT_W-1:0];
                end
            end
            if ((state_reg == ST_UPD_FWD) && act_now) begin
                edge_reg <= edge_step;
            end
            if ((state_reg == ST_UPD_REV) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg   <= wams_kind_t'(s_tuser);
            src_reg    <= s_tdata[5:0];
            dst_reg    <= s_tdata[11:6];
            wv_reg     <= w_in_ext[WEIGHT_BITS-1:0];
            src_ok_reg <= in_src_ok;
            dst_ok_reg <= in_dst_ok;
        end
        if (state_reg == ST_RD_REV) begin
            fwd_reg  <= mat_q;
            dsrc_reg <= deg_q;
        end
        if (state_reg == ST_UPD_FWD) begin
            act_reg      <= act_now;
            status_reg   <= status_now;
            ddst_reg     <= deg_q;
            sdeg_new_reg <= act_now ? step_out : dsrc_reg;
        end
        if ((state_reg == ST_UPD_REV) && out_free) begin
            m_tdata_reg <= {1'b0, edge_reg, deg_out, ew_ext[WFIELD_W-1:0], status_reg};
        end
    end

    // Checks
    a_result_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD_REV) && out_free |=> m_tvalid)
        else $error("finished request did not raise m_tvalid");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("request accepted during the clearing sweep");

    a_edges_hold_on_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD_FWD) && !act_now |=> $stable(edge_reg))
        else $error("edge count changed on a request that made no change");

    a_range_blocks_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD_FWD) && !range_ok |-> !mat_we && !deg_we)
        else $error("out-of-range request wrote a memory");

endmodule

[rtl/wams_sat_step.sv]
// Saturating up/down step shared by the degree and edge counters.
module wams_sat_step #(
    parameter int WIDTH = 8
) (
    input  logic [WIDTH-1:0] value_in,
    input  logic             count_up,
    output logic [WIDTH-1:0] value_out
);

    always_comb begin
        priority if (count_up && (value_in == '1)) begin
            value_out = value_in;
        end else if (count_up) begin
            value_out = value_in + WIDTH'(1);
        end else if (value_in == '0) begin
            value_out = value_in;
        end else begin
            value_out = value_in - WIDTH'(1);
        end
    end

endmodule
